// ----- rtl/core/mlcd_pkg.sv -----
// shared types, constants and rounding helpers for the mouse-look camera direction block
package mlcd_pkg;

    // angle units are 1/256 degree
    localparam int FullTurn       = 92160;
    localparam int QuarterTurn    = 23040;
    localparam int ModSteps       = 9;
    localparam int ModBias        = FullTurn * (1 << (ModSteps - 1));

    // cordic set-up
    localparam int TrigIterations = 16;
    localparam int CordicSteps    = (TrigIterations < 24) ? TrigIterations : 24;
    localparam int XyWidth        = 34;
    localparam int ZWidth         = 33;
    localparam int ProdWidth      = 2 * XyWidth;

    localparam logic signed [XyWidth-1:0] CordicGain = 34'sh0_26DD_3B6A;
    localparam logic signed [XyWidth-1:0] RadScale   = 34'sd4797524476;

    // atan(2^-i) in Q30
    localparam logic [30:0] AtanTable [24] = '{
        31'h3243F6A8, 31'h1DAC6705, 31'h0FADBAFC, 31'h07F56EA6, 31'h03FEAB76, 31'h01FFD55B,
        31'h00FFFAAA, 31'h007FFF55, 31'h003FFFEA, 31'h001FFFFD, 31'h000FFFFF, 31'h0007FFFF,
        31'h0003FFFF, 31'h0001FFFF, 31'h0000FFFF, 31'h00007FFF, 31'h00003FFF, 31'h00001FFF,
        31'h00000FFF, 31'h000007FF, 31'h000003FF, 31'h000001FF, 31'h000000FF, 31'h0000007F
    };

    // configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CfgSensitivity = 1'b0;
    localparam t_cfg_idx CfgPitchLimit  = 1'b1;

    localparam logic [15:0] SensitivityReset = 16'd3277;
    localparam logic [14:0] PitchLimitReset  = 15'd22784;
    localparam logic [16:0] YawReset         = 17'd69120;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MULX,
        S_MULY,
        S_ANG,
        S_MOD,
        S_QUAD,
        S_ZYAW,
        S_CLOAD,
        S_CORD,
        S_ZPIT,
        S_MULA,
        S_MULB,
        S_MULC,
        S_FIN
    } t_state;

    // round to nearest by a right shift with floor, then saturate to 16 bits
    function automatic logic signed [15:0] round_sat(input logic signed [ProdWidth-1:0] v,
                                                     input int sh);
        logic signed [ProdWidth-1:0] half;
        logic signed [ProdWidth-1:0] t;
        half = ProdWidth'(1) <<< (sh - 1);
        t    = (v + half) >>> sh;
        if (t > ProdWidth'(32767)) begin
            return 16'sh7FFF;
        end else if (t < -ProdWidth'(32768)) begin
            return 16'sh8000;
        end
        return t[15:0];
    endfunction

    // reduction step for the yaw modulo: one full turn times 2^k
    function automatic logic [25:0] mod_step(input logic [3:0] k);
        return 26'(FullTurn) << k;
    endfunction

endpackage

// ----- rtl/core/mlcd_if.sv -----
// request channels for cursor positions in and view directions out
interface mlcd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;

    modport source (output valid, output cursor_x, output cursor_y, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, output ready);
endinterface

interface mlcd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;

    modport source (output valid, output front_x, output front_y, output front_z, input ready);
    modport sink   (input valid, input front_x, input front_y, input front_z, output ready);
endinterface

// ----- rtl/core/mouse_look_camera_direction.sv -----
// mouse-look camera: cursor deltas to yaw and pitch, then unit view direction by cordic
// a new request is accepted only in the idle state; one shared multiplier and one cordic
// stage run the two angle passes one after the other, and the yaw modulo takes 9 steps
// the result register frees the input side as soon as the result is loaded
// synchronous active-low reset: configuration and camera state to defaults, yaw 270 degrees, first request pending
module mouse_look_camera_direction import mlcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    mlcd_in_if.sink     i_in,
    mlcd_out_if.source  o_out
);

    t_state r_state, n_state;

    // configuration
    logic [15:0] r_sens;
    logic [14:0] r_plim;

    // camera state
    logic signed [15:0] r_prev_x, r_prev_y;
    logic               r_first;
    logic        [16:0] r_yaw;
    logic signed [15:0] r_pitch;

    // working registers
    logic signed [16:0]          r_dx, r_dy;
    logic signed [24:0]          r_ay;
    logic        [25:0]          r_mod;
    logic        [4:0]           r_cnt;
    logic        [1:0]           r_quad;
    logic        [14:0]          r_resid;
    logic        [14:0]          r_pmag;
    logic                        r_phase_pitch;
    logic signed [XyWidth-1:0]   r_x, r_y;
    logic signed [ZWidth-1:0]    r_z;
    logic signed [XyWidth-1:0]   r_yc, r_ys, r_pc, r_ps;
    logic signed [ProdWidth-1:0] r_prod;
    logic signed [15:0]          r_fx, r_fy, r_fz;

    // result register
    logic               r_out_valid;
    logic signed [15:0] r_out_x, r_out_y, r_out_z;

    logic signed [XyWidth-1:0]   mul_a, mul_b;
    logic signed [ProdWidth-1:0] prod_rnd;
    logic signed [24:0]          ap;
    logic signed [26:0]          yaw_sum;
    logic signed [25:0]          pitch_sum, lim, pitch_new;
    logic        [14:0]          lim_raw;
    logic        [25:0]          mod_cmp;
    logic signed [XyWidth-1:0]   sh_x, sh_y, n_x, n_y;
    logic signed [ZWidth-1:0]    at, n_z;
    logic                        cord_last, out_free, in_acc;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_MULX: begin
                mul_a = XyWidth'(r_dx);
                mul_b = XyWidth'({1'b0, r_sens});
            end
            S_MULY: begin
                mul_a = XyWidth'(r_dy);
                mul_b = XyWidth'({1'b0, r_sens});
            end
            S_ZYAW: begin
                mul_a = XyWidth'({1'b0, r_resid});
                mul_b = RadScale;
            end
            S_ZPIT: begin
                mul_a = XyWidth'({1'b0, r_pmag});
                mul_b = RadScale;
            end
            S_MULA: begin
                mul_a = r_yc;
                mul_b = r_x;
            end
            default: begin
                mul_a = r_ys;
                mul_b = r_pc;
            end
        endcase
    end

    // angle step rounding, yaw bias for the modulo, pitch clamp
    always_comb begin
        prod_rnd  = r_prod + ProdWidth'(128);
        ap        = prod_rnd[32:8];
        yaw_sum   = $signed({10'd0, r_yaw}) + 27'(r_ay) + 27'(ModBias);
        lim_raw   = (r_plim > 15'(QuarterTurn)) ? 15'(QuarterTurn) : r_plim;
        lim       = $signed({11'd0, lim_raw});
        pitch_sum = 26'(r_pitch) + 26'(ap);
        if (pitch_sum > lim) begin
            pitch_new = lim;
        end else if (pitch_sum < -lim) begin
            pitch_new = -lim;
        end else begin
            pitch_new = pitch_sum;
        end
        mod_cmp = mod_step(r_cnt[3:0]);
    end

    // one cordic rotation step
    always_comb begin
        sh_x = r_x >>> r_cnt;
        sh_y = r_y >>> r_cnt;
        at   = ZWidth'({1'b0, AtanTable[r_cnt]});
        if (!r_z[ZWidth-1]) begin
            n_x = r_x - sh_y;
            n_y = r_y + sh_x;
            n_z = r_z - at;
        end else begin
            n_x = r_x + sh_y;
            n_y = r_y - sh_x;
            n_z = r_z + at;
        end
        cord_last = (r_cnt == 5'(CordicSteps - 1));
    end

    // sequencer next state and input ready
    always_comb begin
        n_state    = r_state;
        i_in.ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_MULX;
            S_MULX:  n_state = S_MULY;
            S_MULY:  n_state = S_ANG;
            S_ANG:   n_state = S_MOD;
            S_MOD:   if (r_cnt == 5'd0) n_state = S_QUAD;
            S_QUAD:  n_state = S_ZYAW;
            S_ZYAW:  n_state = S_CLOAD;
            S_CLOAD: n_state = S_CORD;
            S_CORD: begin
                if (cord_last) begin
                    n_state = r_phase_pitch ? S_MULA : S_ZPIT;
                end
            end
            S_ZPIT:  n_state = S_CLOAD;
            S_MULA:  n_state = S_MULB;
            S_MULB:  n_state = S_MULC;
            S_MULC:  n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.front_x = r_out_x;
    assign o_out.front_y = r_out_y;
    assign o_out.front_z = r_out_z;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration, camera state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens      <= SensitivityReset;
            r_plim      <= PitchLimitReset;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_first     <= 1'b1;
            r_yaw       <= YawReset;
            r_pitch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CfgSensitivity: r_sens <= i_cfg_data;
                    CfgPitchLimit:  r_plim <= i_cfg_data[14:0];
                    default:        r_sens <= r_sens;
                endcase
            end
            if (in_acc) begin
                r_prev_x <= i_in.cursor_x;
                r_prev_y <= i_in.cursor_y;
                r_first  <= 1'b0;
            end
            if (r_state == S_ANG) begin
                r_pitch <= pitch_new[15:0];
            end
            if (r_state == S_QUAD) begin
                r_yaw <= r_mod[16:0];
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_IDLE: begin
                if (r_first) begin
                    r_dx <= '0;
                    r_dy <= '0;
                end else begin
                    r_dx <= 17'(i_in.cursor_x) - 17'(r_prev_x);
                    r_dy <= 17'(r_prev_y) - 17'(i_in.cursor_y);
                end
            end
            S_MULY: r_ay <= prod_rnd[32:8];
            S_ANG: begin
                r_mod <= yaw_sum[25:0];
                r_cnt <= 5'(ModSteps - 1);
            end
            S_MOD: begin
                if (r_mod >= mod_cmp) begin
                    r_mod <= r_mod - mod_cmp;
                end
                r_cnt <= r_cnt - 5'd1;
            end
            S_QUAD: begin
                // quadrant and residue of the wrapped yaw
                if (r_mod < 26'(QuarterTurn)) begin
                    r_quad  <= 2'd0;
                    r_resid <= r_mod[14:0];
                end else if (r_mod < 26'(2 * QuarterTurn)) begin
                    r_quad  <= 2'd1;
                    r_resid <= 15'(r_mod - 26'(QuarterTurn));
                end else if (r_mod < 26'(3 * QuarterTurn)) begin
                    r_quad  <= 2'd2;
                    r_resid <= 15'(r_mod - 26'(2 * QuarterTurn));
                end else begin
                    r_quad  <= 2'd3;
                    r_resid <= 15'(r_mod - 26'(3 * QuarterTurn));
                end
                r_pmag        <= r_pitch[15] ? 15'(-r_pitch) : r_pitch[14:0];
                r_phase_pitch <= 1'b0;
            end
            S_CLOAD: begin
                r_x   <= CordicGain;
                r_y   <= '0;
                r_z   <= ZWidth'({2'b00, r_prod[46:16]});
                r_cnt <= '0;
            end
            S_CORD: begin
                r_x   <= n_x;
                r_y   <= n_y;
                r_z   <= n_z;
                r_cnt <= r_cnt + 5'd1;
            end
            S_ZPIT: begin
                // map the yaw pair into its quadrant
                unique case (r_quad)
                    2'd0: begin r_yc <= r_x;  r_ys <= r_y;  end
                    2'd1: begin r_yc <= -r_y; r_ys <= r_x;  end
                    2'd2: begin r_yc <= -r_x; r_ys <= -r_y; end
                    default: begin r_yc <= r_y; r_ys <= -r_x; end
                endcase
                r_phase_pitch <= 1'b1;
            end
            S_MULA: begin
                r_pc <= r_x;
                r_ps <= r_pitch[15] ? -r_y : r_y;
            end
            S_MULB: r_fx <= round_sat(r_prod, 45);
            S_MULC: begin
                r_fz <= round_sat(r_prod, 45);
                r_fy <= round_sat(ProdWidth'(r_ps), 15);
            end
            S_FIN: begin
                if (out_free) begin
                    r_out_x <= r_fx;
                    r_out_y <= r_fy;
                    r_out_z <= r_fz;
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

`ifndef SYNTHESIS
    // wrapped yaw stays within one turn
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_yaw < 17'(FullTurn))
        else $error("yaw out of range");

    // pitch never leaves the quarter-turn clamp
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pitch <= 16'sd23040) && (r_pitch >= -16'sd23040))
        else $error("pitch out of range");

    // an accepted request starts the sequence
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_MULX))
        else $error("sequence did not start");

    // a loaded result shows as valid on the next cycle
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not presented");
`endif

endmodule
